[rtl/core/mgi_pkg.sv]
// shared types, constants and helper functions of the multilinear grid interpolator
`default_nettype none

package mgi_pkg;

	// grid shape
	localparam int DIMS       = 3;
	localparam int POINTS     = 16;
	localparam int NCOORD     = 3;
	localparam int CW         = 2;
	localparam int GRID_DEPTH = 4096;
	localparam int AW         = 12;

	// number formats
	localparam int VW   = 32;
	localparam int FRAC = 16;
	localparam int MW   = VW + 1;
	localparam int PW   = 2 * MW;
	localparam int SW   = PW - FRAC;
	localparam int HW   = SW - FRAC;
	localparam int IW   = $clog2(POINTS);
	localparam int AXW  = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam int SUMW = VW + DIMS;

	localparam logic [VW-1:0] ONE_Q16 = VW'(1 << FRAC);
	localparam logic [VW-1:0] SAT_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic [VW-1:0] SAT_MIN = {1'b1, {(VW-1){1'b0}}};

	// action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// register indexes
	typedef enum logic [2:0] {
		REG_ORIGIN_AXIS0   = 3'd0,
		REG_ORIGIN_AXIS1   = 3'd1,
		REG_ORIGIN_AXIS2   = 3'd2,
		REG_INV_STEP_AXIS0 = 3'd3,
		REG_INV_STEP_AXIS1 = 3'd4,
		REG_INV_STEP_AXIS2 = 3'd5
	} reg_index_t;

	typedef logic [NCOORD-1:0][VW-1:0] coord_vec_t;
	typedef logic [DIMS-1:0][IW-1:0]   cell_vec_t;

	typedef struct packed {
		coord_vec_t origin;
		coord_vec_t inv_step;
	} cfg_t;

	typedef struct packed {
		logic [MW-1:0] a;
		logic [MW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] addr;
		logic [VW-1:0] wdata;
	} ram_req_t;

	// saturate a signed 64-bit value to signed 32 bits
	function automatic logic [VW-1:0] sat32(input logic [63:0] x);
		logic [63-VW+1:0] top;
		top = x[63:VW-1];
		if (top == '0 || top == '1)
			return x[VW-1:0];
		else if (x[63])
			return SAT_MIN;
		else
			return SAT_MAX;
	endfunction

	// node stride of each axis, modulo the table depth
	function automatic logic [DIMS-1:0][AW-1:0] stride_table();
		logic [DIMS-1:0][AW-1:0] t;
		int s;
		s = 1;
		for (int d = 0; d < DIMS; d++) begin
			t[d] = AW'(s);
			s = (s * POINTS) & (GRID_DEPTH - 1);
		end
		return t;
	endfunction

	localparam logic [DIMS-1:0][AW-1:0] STRIDE = stride_table();

	// table address of one corner of the cell
	function automatic logic [AW-1:0] corner_addr(input cell_vec_t cells,
		input logic [DIMS-1:0] corner);
		logic [AW-1:0] addr;
		logic [IW:0]   idx;
		addr = '0;
		for (int d = 0; d < DIMS; d++) begin
			idx  = {1'b0, cells[d]} + (IW+1)'(corner[d]);
			addr = addr + AW'(AW'(idx) * STRIDE[d]);
		end
		return addr;
	endfunction

endpackage

`default_nettype wire

[rtl/core/mgi_ram.sv]
// generic single-port ram with registered read
`default_nettype none

module mgi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/core/mgi_mul.sv]
// shared signed multiplier with registered product
`default_nettype none

module mgi_mul import mgi_pkg::*; (
	input  wire logic          clk,
	input  wire mul_req_t      req,
	output logic     [PW-1:0]  prod
);

	logic signed [PW-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= $signed(req.a) * $signed(req.b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

[rtl/core/mgi_seq.sv]
// sequencer: per-axis cell and offset, then corner weighting and accumulation
`default_nettype none

module mgi_seq import mgi_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          action,
	input  wire coord_vec_t    coord,
	input  wire logic [AW-1:0] grid_address,
	input  wire logic [VW-1:0] grid_value,
	input  wire cfg_t          cfg,
	output mul_req_t           mul_req,
	input  wire logic [PW-1:0] mul_prod,
	output ram_req_t           ram_req,
	input  wire logic [VW-1:0] ram_rdata,
	output logic               busy,
	output logic               done,
	output logic [VW-1:0]      interp_value
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_DIFF = 9'b000000010,
		S_AMUL = 9'b000000100,
		S_AFIX = 9'b000001000,
		S_CRD  = 9'b000010000,
		S_CLD  = 9'b000100000,
		S_WMUL = 9'b001000000,
		S_WSAT = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t                   state_q;
	logic [AXW-1:0]           d_q;
	logic [DIMS-1:0]          k_q;
	logic                     done_q;
	coord_vec_t               coord_q;
	logic [MW-1:0]            diff_q;
	cell_vec_t                cell_q;
	logic [DIMS-1:0][VW-1:0]  offs_q;
	logic [VW-1:0]            v_q;
	logic [SUMW-1:0]          acc_q;
	logic [VW-1:0]            result_q;

	logic                     accept;
	logic                     query;
	logic                     axis_in;
	logic [CW-1:0]            ci;
	logic [VW-1:0]            coord_sel;
	logic [VW-1:0]            origin_sel;
	logic [VW-1:0]            inv_sel;
	logic [MW-1:0]            diff_d;
	logic                     last_axis;
	logic                     last_corner;
	logic [SW-1:0]            s_fix;
	logic [HW-1:0]            hi;
	logic                     diff_pos;
	logic [IW-1:0]            cell_d;
	logic [SW-1:0]            offs_wide;
	logic [VW-1:0]            offs_d;
	logic [VW-1:0]            offs_sel;
	logic [MW-1:0]            w_d;
	logic [VW-1:0]            v_new;

	assign accept = start && (state_q == S_IDLE);
	assign query  = accept && (action == ACT_QUERY);

	// axis operands, axes past the coordinate inputs sit at the origin
	assign axis_in    = int'(d_q) < NCOORD;
	assign ci         = CW'(d_q);
	assign coord_sel  = axis_in ? coord_q[ci] : '0;
	assign origin_sel = axis_in ? cfg.origin[ci] : '0;
	assign inv_sel    = axis_in ? cfg.inv_step[ci] : ONE_Q16;
	assign diff_d     = {coord_sel[VW-1], coord_sel} - {origin_sel[VW-1], origin_sel};

	assign last_axis   = (d_q == AXW'(DIMS - 1));
	assign last_corner = &k_q;

	// cell index and offset from the scaled distance
	assign s_fix    = mul_prod[PW-1:FRAC];
	assign hi       = s_fix[SW-1:FRAC];
	assign diff_pos = !diff_q[MW-1] && (diff_q != '0);

	always_comb begin
		if (!diff_pos)
			cell_d = '0;
		else if ($signed(hi) >= $signed(HW'(POINTS - 1)))
			cell_d = IW'(POINTS - 2);
		else
			cell_d = hi[IW-1:0];
	end

	assign offs_wide = s_fix - {{(HW-IW){1'b0}}, cell_d, {FRAC{1'b0}}};
	assign offs_d    = sat32({{(64-SW){offs_wide[SW-1]}}, offs_wide});

	// corner weight: offset or one minus offset
	assign offs_sel = offs_q[d_q];
	assign w_d = k_q[d_q] ? {offs_sel[VW-1], offs_sel}
	                      : ({1'b0, ONE_Q16} - {offs_sel[VW-1], offs_sel});
	assign v_new = sat32({{(64-SW){s_fix[SW-1]}}, s_fix});

	always_comb begin
		if (state_q == S_WMUL) begin
			mul_req.a = {v_q[VW-1], v_q};
			mul_req.b = w_d;
		end else begin
			mul_req.a = diff_q;
			mul_req.b = {1'b0, inv_sel};
		end
	end

	assign ram_req.we    = accept && (action == ACT_WRITE);
	assign ram_req.addr  = (state_q == S_IDLE) ? grid_address : corner_addr(cell_q, k_q);
	assign ram_req.wdata = grid_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			d_q     <= '0;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: begin
					if (query) begin
						state_q <= S_DIFF;
						d_q     <= '0;
						k_q     <= '0;
					end
				end
				S_DIFF: state_q <= S_AMUL;
				S_AMUL: state_q <= S_AFIX;
				S_AFIX: begin
					if (last_axis) begin
						d_q     <= '0;
						state_q <= S_CRD;
					end else begin
						d_q     <= d_q + AXW'(1);
						state_q <= S_DIFF;
					end
				end
				S_CRD: state_q <= S_CLD;
				S_CLD: begin
					d_q     <= '0;
					state_q <= S_WMUL;
				end
				S_WMUL: state_q <= S_WSAT;
				S_WSAT: begin
					if (last_axis) begin
						d_q <= '0;
						if (last_corner) begin
							state_q <= S_DONE;
						end else begin
							k_q     <= k_q + DIMS'(1);
							state_q <= S_CRD;
						end
					end else begin
						d_q     <= d_q + AXW'(1);
						state_q <= S_WMUL;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (query) begin
			coord_q <= coord;
			acc_q   <= '0;
		end
		if (state_q == S_DIFF)
			diff_q <= diff_d;
		if (state_q == S_AFIX) begin
			cell_q[d_q] <= cell_d;
			offs_q[d_q] <= offs_d;
		end
		if (state_q == S_CLD)
			v_q <= ram_rdata;
		if (state_q == S_WSAT) begin
			v_q <= v_new;
			if (last_axis)
				acc_q <= acc_q + {{(SUMW-VW){v_new[VW-1]}}, v_new};
		end
		if (state_q == S_DONE)
			result_q <= sat32({{(64-SUMW){acc_q[SUMW-1]}}, acc_q});
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign interp_value = result_q;

endmodule

`default_nettype wire

[rtl/core/multilinear_grid_interpolator.sv]
// top level of the multilinear grid interpolator
//
// channel    | handshake            | payload
// -----------+----------------------+---------------------------------------------
// command    | start, busy          | action, coordinate_0..2, grid_address,
//            |                      | grid_value
// config     | cfg_we               | cfg_index, cfg_wdata
// result     | done (one-cycle)     | interp_value
//
// a write transaction stores one node in the table in the cycle it is taken;
// busy stays low and the next transaction can follow at once
// a query transaction sends every product through the one shared multiplier, three
// steps per axis and two per axis and corner, plus one table read per corner
// done is high for one cycle as busy falls, interp_value holds until
// the next query ends; the result cannot be held off
// reset clears the sequencer and resets the configuration registers; table contents
// are undefined until written, no clearing pass
`default_nettype none

module multilinear_grid_interpolator import mgi_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// command transaction
	input  wire logic          start,
	output logic               busy,
	input  wire logic          action,
	input  wire logic [VW-1:0] coordinate_0,
	input  wire logic [VW-1:0] coordinate_1,
	input  wire logic [VW-1:0] coordinate_2,
	input  wire logic [AW-1:0] grid_address,
	input  wire logic [VW-1:0] grid_value,
	// result
	output logic               done,
	output logic [VW-1:0]      interp_value,
	// configuration writes
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [VW-1:0] cfg_wdata
);

	cfg_t          cfg_q;
	mul_req_t      mul_req;
	logic [PW-1:0] mul_prod;
	ram_req_t      ram_req;
	logic [VW-1:0] ram_rdata;
	coord_vec_t    coord;

	// configuration registers, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin   <= '0;
			cfg_q.inv_step <= {NCOORD{ONE_Q16}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_AXIS0:   cfg_q.origin[0]   <= cfg_wdata;
				REG_ORIGIN_AXIS1:   cfg_q.origin[1]   <= cfg_wdata;
				REG_ORIGIN_AXIS2:   cfg_q.origin[2]   <= cfg_wdata;
				REG_INV_STEP_AXIS0: cfg_q.inv_step[0] <= cfg_wdata;
				REG_INV_STEP_AXIS1: cfg_q.inv_step[1] <= cfg_wdata;
				REG_INV_STEP_AXIS2: cfg_q.inv_step[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign coord = {coordinate_2, coordinate_1, coordinate_0};

	// sequencer owns all control; multiplier and table are shared resources
	mgi_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.coord        (coord),
		.grid_address (grid_address),
		.grid_value   (grid_value),
		.cfg          (cfg_q),
		.mul_req      (mul_req),
		.mul_prod     (mul_prod),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata),
		.busy         (busy),
		.done         (done),
		.interp_value (interp_value)
	);

	// one 33x33 signed multiplier, product registered
	mgi_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (mul_prod)
	);

	// node table, one access per cycle
	mgi_ram #(
		.WIDTH (VW),
		.DEPTH (GRID_DEPTH)
	) u_grid_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

[rtl/core/mgi_chk.sv]
// port-level checker of the interpolator and its bind
`default_nettype none

module mgi_chk import mgi_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic action,
	input wire logic done
);

	// a result only shows once the block is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// a query transaction keeps the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_QUERY) |=> busy)
		else $error("query taken without going busy");

	// a write transaction finishes in its own cycle
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_WRITE) |=> !busy)
		else $error("write made the block busy");

	// busy only ends with a result
	a_busy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy ended without a result");

	// the result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

endmodule

bind multilinear_grid_interpolator mgi_chk u_mgi_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.action (action),
	.done   (done)
);

`default_nettype wire
